// ===== design/mcfe_pkg.sv =====
// shared types and constants for the motor command frame encoder
// no dependencies
`timescale 1ns / 1ps
package mcfe_pkg;
    localparam int LIMIT_W = 31;
    localparam int VALUE_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_VALUES = 5;

    localparam logic [1:0] REQ_MOTION  = 2'd0;
    localparam logic [1:0] REQ_ENABLE  = 2'd1;
    localparam logic [1:0] REQ_DISABLE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_POSITION  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TORQUE    = 3'd4;

    localparam logic [63:0] ENABLE_FRAME  = 64'hFFFF_FFFF_FFFF_FFFC;
    localparam logic [63:0] DISABLE_FRAME = 64'hFFFF_FFFF_FFFF_FFFD;

    // classified item passed from front to back
    typedef struct packed {
        logic [7:0]  bus;
        logic [10:0] id;
        logic        rejected;
        logic        fixed;
        logic [63:0] fixed_frame;
        // per value: clamped offset (0..span) and span, value 0 is position
        logic [NUM_VALUES-1:0][LIMIT_W:0] offset;
        logic [NUM_VALUES-1:0][LIMIT_W:0] span;
    } t_job;
endpackage

// ===== design/mcfe_front.sv =====
// front end: takes requests, clamps values and queues classified jobs
// depends on mcfe_pkg
`timescale 1ns / 1ps
module mcfe_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_take,
    input  logic [1:0]                   i_req_type,
    input  logic [7:0]                   i_bus_index,
    input  logic [10:0]                  i_target_id,
    input  logic signed [31:0]           i_target_position,
    input  logic signed [31:0]           i_target_velocity,
    input  logic signed [31:0]           i_stiffness_gain,
    input  logic signed [31:0]           i_damping_gain,
    input  logic signed [31:0]           i_feedforward_torque,
    input  logic [mcfe_pkg::LIMIT_W-1:0] i_lim [mcfe_pkg::NUM_VALUES],
    output logic                         o_full,
    output logic                         o_valid,
    output mcfe_pkg::t_job               o_job,
    input  logic                         i_pop
);
    import mcfe_pkg::*;

    logic [VALUE_W-1:0] vals [NUM_VALUES];
    t_job job;
    t_job r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign vals[0] = i_target_position;
    assign vals[1] = i_target_velocity;
    assign vals[2] = i_stiffness_gain;
    assign vals[3] = i_damping_gain;
    assign vals[4] = i_feedforward_torque;

    always_comb begin
        logic signed [33:0] x, lim;
        job.bus = i_bus_index;
        job.id = i_target_id;
        job.rejected = (i_target_id == 11'd0);
        job.fixed = (i_req_type == REQ_ENABLE) || (i_req_type == REQ_DISABLE);
        job.fixed_frame = (i_req_type == REQ_ENABLE) ? ENABLE_FRAME : DISABLE_FRAME;
        for (int k = 0; k < NUM_VALUES; k++) begin
            x = {{2{vals[k][31]}}, vals[k]};
            lim = {3'b000, i_lim[k]};
            if (k == 2 || k == 3) begin
                if (x < 0) x = '0;
                if (x > lim) x = lim;
                job.offset[k] = x[LIMIT_W:0];
                job.span[k] = {1'b0, i_lim[k]};
            end else begin
                if (x < -lim) x = -lim;
                if (x > lim) x = lim;
                x = x + lim;
                job.offset[k] = x[LIMIT_W:0];
                job.span[k] = {i_lim[k], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_take) begin
                r_q[r_wp] <= job;
                r_wp <= ~r_wp;
            end
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_take} - {1'b0, i_pop};
        end
    end

    assign o_full = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job = r_q[r_rp];
endmodule

// ===== design/mcfe_back.sv =====
// back end: scales offsets to codes with a serial divider and packs the frame
// depends on mcfe_pkg
`timescale 1ns / 1ps
module mcfe_back #(
    parameter int POSITION_BITS = 16,
    parameter int FIELD_BITS = 12
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  mcfe_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_strobe,
    output logic [7:0]     o_bus_out,
    output logic [10:0]    o_frame_id,
    output logic [63:0]    o_frame_payload,
    output logic           o_rejected
);
    import mcfe_pkg::*;

    localparam int NUM_W = 50;
    localparam int QB = 17;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} t_state;

    t_state r_state;
    logic [2:0] r_sel;
    logic [5:0] r_bit;
    logic [NUM_W-1:0] r_num;
    logic [LIMIT_W+2:0] r_den;
    logic [LIMIT_W+2:0] r_rem;
    logic [QB-1:0] r_quo;
    logic [15:0] r_code [NUM_VALUES];
    t_job r_job;

    logic [15:0] top;
    logic [LIMIT_W+3:0] trial;

    assign top = (r_sel == 3'd0) ? 16'((1 << POSITION_BITS) - 1)
                                 : 16'((1 << FIELD_BITS) - 1);
    assign trial = {r_rem, r_num[NUM_W-1]} - {1'b0, r_den};

    assign o_pop = (r_state == S_IDLE) && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_job <= i_job;
                    r_sel <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    // numerator 2*offset*top + span, denominator 2*span
                    r_num <= NUM_W'({r_job.offset[r_sel], 1'b0}) * NUM_W'(top)
                           + NUM_W'(r_job.span[r_sel]);
                    r_den <= {1'b0, r_job.span[r_sel], 1'b0};
                    r_rem <= '0;
                    r_bit <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_den == '0) begin
                        r_code[r_sel] <= '0;
                    end
                    // restoring division, one quotient bit a cycle
                    if (r_den != '0) begin
                        r_num <= {r_num[NUM_W-2:0], 1'b0};
                        if (!trial[LIMIT_W+3]) begin
                            r_rem <= trial[LIMIT_W+2:0];
                            r_quo <= {r_quo[QB-2:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[LIMIT_W+1:0], r_num[NUM_W-1]};
                            r_quo <= {r_quo[QB-2:0], 1'b0};
                        end
                    end
                    r_bit <= r_bit + 6'd1;
                    if (r_den == '0 || r_bit == 6'(NUM_W - 1)) begin
                        if (r_den != '0)
                            r_code[r_sel] <= 16'({r_quo[QB-2:0],
                                                  !trial[LIMIT_W+3]});
                        if (r_sel == 3'(NUM_VALUES - 1)) r_state <= S_DONE;
                        else begin
                            r_sel <= r_sel + 3'd1;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_DONE: begin
                    o_strobe <= 1'b1;
                    o_bus_out <= r_job.bus;
                    o_frame_id <= r_job.id;
                    o_rejected <= r_job.rejected;
                    if (r_job.rejected) o_frame_payload <= '0;
                    else if (r_job.fixed) o_frame_payload <= r_job.fixed_frame;
                    else o_frame_payload <= {r_code[0], r_code[1][11:0],
                        r_code[2][11:0], r_code[3][11:0], r_code[4][11:0]};
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== design/motor_command_frame_encoder_top.sv =====
// top level of the motor command frame encoder: limit registers, front, back
// depends on mcfe_pkg, mcfe_front, mcfe_back
`timescale 1ns / 1ps
// a request is taken when start is high and busy low; its frame appears for
// one cycle with o_done. the back end takes every request, whatever its kind,
// through the same steps: it loads it, then for each of the five values runs
// a multiply step and a one-bit-a-cycle divider, then registers the frame; a
// value whose limit is zero skips its divide. a two-deep queue lets two more
// requests wait; busy is high while that queue is full.
// results cannot be held off by the receiver.
module motor_command_frame_encoder_top #(
    parameter int POSITION_BITS = 16,
    parameter int FIELD_BITS = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [30:0]        i_cfg_data,
    input  logic [1:0]         i_req_type,
    input  logic [7:0]         i_bus_index,
    input  logic [10:0]        i_target_id,
    input  logic signed [31:0] i_target_position,
    input  logic signed [31:0] i_target_velocity,
    input  logic signed [31:0] i_stiffness_gain,
    input  logic signed [31:0] i_damping_gain,
    input  logic signed [31:0] i_feedforward_torque,
    output logic               o_done,
    output logic [7:0]         o_bus_out,
    output logic [10:0]        o_frame_id,
    output logic [63:0]        o_frame_payload,
    output logic               o_rejected
);
    import mcfe_pkg::*;

    logic [LIMIT_W-1:0] r_lim [NUM_VALUES];
    logic full, valid, pop;
    t_job job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_VALUES; k++) r_lim[k] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_POSITION:  r_lim[0] <= i_cfg_data;
                REG_VELOCITY:  r_lim[1] <= i_cfg_data;
                REG_STIFFNESS: r_lim[2] <= i_cfg_data;
                REG_DAMPING:   r_lim[3] <= i_cfg_data;
                REG_TORQUE:    r_lim[4] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = full;

    mcfe_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(start && !full),
        .i_req_type(i_req_type), .i_bus_index(i_bus_index),
        .i_target_id(i_target_id), .i_target_position(i_target_position),
        .i_target_velocity(i_target_velocity), .i_stiffness_gain(i_stiffness_gain),
        .i_damping_gain(i_damping_gain), .i_feedforward_torque(i_feedforward_torque),
        .i_lim(r_lim), .o_full(full), .o_valid(valid), .o_job(job), .i_pop(pop)
    );

    mcfe_back #(.POSITION_BITS(POSITION_BITS), .FIELD_BITS(FIELD_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(valid), .i_job(job),
        .o_pop(pop), .o_strobe(o_done), .o_bus_out(o_bus_out),
        .o_frame_id(o_frame_id), .o_frame_payload(o_frame_payload),
        .o_rejected(o_rejected)
    );
endmodule

// ===== design/mcfe_checker.sv =====
// port-level checks for the motor command frame encoder
// depends on motor_command_frame_encoder_top
`timescale 1ns / 1ps
module mcfe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_done,
    input logic        o_rejected,
    input logic [10:0] o_frame_id,
    input logic [63:0] o_frame_payload
);
    a_rej_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rejected == (o_frame_id == 11'd0)))
        else $error("rejected flag does not follow identifier");
    a_rej_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_rejected |-> o_frame_payload == 64'd0)
        else $error("rejected frame has payload");
    a_done_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("back-to-back results");
endmodule

bind motor_command_frame_encoder_top mcfe_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_done(o_done), .o_rejected(o_rejected),
    .o_frame_id(o_frame_id), .o_frame_payload(o_frame_payload)
);

// ===== tb/tb.sv =====
// self-checking testbench for motor_command_frame_encoder_top: a directed table, then random
// phases under changing limits, each frame checked against its row or a bit-exact predictor
// depends on mcfe_pkg and motor_command_frame_encoder_top
`timescale 1ns / 1ps
module tb;
    import mcfe_pkg::*;

    localparam int POS_BITS = 16;
    localparam int FLD_BITS = 12;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASES = 10;
    localparam int PHASE_ITEMS = 155;
    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;
    localparam logic [1:0] REQ_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         bus;
        logic [10:0]        id;
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] kp;
        logic signed [31:0] kd;
        logic signed [31:0] trq;
    } motor_req_t;

    typedef struct packed {
        logic [7:0]  bus;
        logic [10:0] id;
        logic [63:0] payload;
        logic        rej;
    } can_frame_t;

    typedef struct packed {
        logic       after_cfg;
        motor_req_t req;
        logic       known;
        can_frame_t frame;
    } table_row_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_index;
    logic [30:0]        i_cfg_data;
    logic [1:0]         i_req_type;
    logic [7:0]         i_bus_index;
    logic [10:0]        i_target_id;
    logic signed [31:0] i_target_position;
    logic signed [31:0] i_target_velocity;
    logic signed [31:0] i_stiffness_gain;
    logic signed [31:0] i_damping_gain;
    logic signed [31:0] i_feedforward_torque;
    logic               o_done;
    logic [7:0]         o_bus_out;
    logic [10:0]        o_frame_id;
    logic [63:0]        o_frame_payload;
    logic               o_rejected;

    logic [30:0] limits [5];
    can_frame_t  pending_frames [$];
    int          mismatches = 0;
    int          stall_cycles = 0;
    bit          idling_on = 1;

    motor_command_frame_encoder_top dut (.*);

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SMIN = 32'sh8000_0000;

    table_row_t dir_rows [] = '{
        '{1'b0, '{REQ_MOTION, 8'h00, 11'h001, SMAX, SMAX, SMAX, SMAX, SMAX},
          1'b1, '{8'h00, 11'h001, 64'h0, 1'b0}},
        '{1'b0, '{REQ_MOTION, 8'hFF, 11'h7FF, SMIN, SMIN, SMIN, SMIN, SMIN},
          1'b1, '{8'hFF, 11'h7FF, 64'h0, 1'b0}},
        '{1'b0, '{REQ_ENABLE, 8'h5A, 11'h123, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0},
          1'b1, '{8'h5A, 11'h123, ENABLE_FRAME, 1'b0}},
        '{1'b0, '{REQ_DISABLE, 8'hA5, 11'h456, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0},
          1'b1, '{8'hA5, 11'h456, DISABLE_FRAME, 1'b0}},
        '{1'b0, '{REQ_SPARE, 8'h01, 11'h002, SMAX, SMIN, SMAX, SMIN, SMAX},
          1'b1, '{8'h01, 11'h002, 64'h0, 1'b0}},
        '{1'b0, '{REQ_MOTION, 8'h33, 11'h000, SMAX, SMAX, SMAX, SMAX, SMAX},
          1'b1, '{8'h33, 11'h000, 64'h0, 1'b1}},
        '{1'b0, '{REQ_ENABLE, 8'hFF, 11'h000, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0},
          1'b1, '{8'hFF, 11'h000, 64'h0, 1'b1}},
        // limits set from here on
        '{1'b1, '{REQ_MOTION, 8'h10, 11'h010, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0},
          1'b0, '0},
        '{1'b1, '{REQ_MOTION, 8'h11, 11'h011, SMAX, SMAX, SMAX, SMAX, SMAX}, 1'b0, '0},
        '{1'b1, '{REQ_MOTION, 8'h12, 11'h012, SMIN, SMIN, SMIN, SMIN, SMIN}, 1'b0, '0},
        '{1'b1, '{REQ_MOTION, 8'h13, 11'h013, 32'sh0001_0000, 32'sh7FFF_FFFF, 32'sh1,
          32'sh0032_0000, 32'sh0}, 1'b0, '0},
        '{1'b1, '{REQ_MOTION, 8'h14, 11'h014, -32'sh0001_0000, -32'sh7FFF_FFFF, -32'sh1,
          32'sh0019_0000, 32'sh1}, 1'b0, '0},
        '{1'b1, '{REQ_MOTION, 8'h15, 11'h015, 32'sh0000_8000, -32'sh0000_8000, 32'sh0,
          32'sh0019_0001, -32'sh1}, 1'b0, '0},
        '{1'b1, '{REQ_SPARE, 8'h16, 11'h016, 32'sh0001_0001, 32'sh1234_5678, 32'sh2,
          32'sh0032_0001, 32'sh7}, 1'b0, '0},
        '{1'b1, '{REQ_ENABLE, 8'h17, 11'h017, SMAX, SMIN, SMAX, SMIN, SMAX},
          1'b1, '{8'h17, 11'h017, ENABLE_FRAME, 1'b0}},
        '{1'b1, '{REQ_DISABLE, 8'h18, 11'h018, SMIN, SMAX, SMIN, SMAX, SMIN},
          1'b1, '{8'h18, 11'h018, DISABLE_FRAME, 1'b0}},
        '{1'b1, '{REQ_DISABLE, 8'h19, 11'h000, SMIN, SMAX, SMIN, SMAX, SMIN},
          1'b1, '{8'h19, 11'h000, 64'h0, 1'b1}}
    };

    function automatic longint unsigned scale_to_code(longint unsigned offs,
                                                      longint unsigned span, int bits);
        longint unsigned top;
        top = (64'd1 << bits) - 1;
        if (span == 0) return 0;
        return (2 * offs * top + span) / (2 * span);
    endfunction

    function automatic longint unsigned symmetric_code(logic signed [31:0] x,
                                                       logic [30:0] lim, int bits);
        longint xs;
        longint l;
        xs = x;
        l = lim;
        if (xs < -l) xs = -l;
        if (xs > l) xs = l;
        return scale_to_code(xs + l, 2 * l, bits);
    endfunction

    function automatic longint unsigned gain_code(logic signed [31:0] x,
                                                  logic [30:0] lim, int bits);
        longint xs;
        longint l;
        xs = x;
        l = lim;
        if (xs < 0) xs = 0;
        if (xs > l) xs = l;
        return scale_to_code(xs, l, bits);
    endfunction

    function automatic can_frame_t encode_frame(motor_req_t r);
        can_frame_t f;
        longint unsigned p, v, kp, kd, t;
        f.bus = r.bus;
        f.id = r.id;
        f.rej = (r.id == 11'd0);
        if (f.rej) begin
            f.payload = 64'h0;
        end else if (r.kind == REQ_ENABLE) begin
            f.payload = ENABLE_FRAME;
        end else if (r.kind == REQ_DISABLE) begin
            f.payload = DISABLE_FRAME;
        end else begin
            p = symmetric_code(r.pos, limits[REG_POSITION], POS_BITS);
            v = symmetric_code(r.vel, limits[REG_VELOCITY], FLD_BITS);
            kp = gain_code(r.kp, limits[REG_STIFFNESS], FLD_BITS);
            kd = gain_code(r.kd, limits[REG_DAMPING], FLD_BITS);
            t = symmetric_code(r.trq, limits[REG_TORQUE], FLD_BITS);
            f.payload = {p[15:0], v[11:0], kp[11:0], kd[11:0], t[11:0]};
        end
        return f;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        can_frame_t want;
        if (i_rst_n && o_done) begin
            if (pending_frames.size() == 0) begin
                report_mismatch("unexpected frame", o_frame_payload, 64'h0);
            end else begin
                want = pending_frames.pop_front();
                if (o_bus_out !== want.bus) report_mismatch("bus", o_bus_out, want.bus);
                if (o_frame_id !== want.id) report_mismatch("id", o_frame_id, want.id);
                if (o_frame_payload !== want.payload)
                    report_mismatch("payload", o_frame_payload, want.payload);
                if (o_rejected !== want.rej) report_mismatch("rejected", o_rejected, want.rej);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (start && !busy)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_req(motor_req_t r, bit known, can_frame_t kf);
        start <= 1'b1;
        i_req_type <= r.kind;
        i_bus_index <= r.bus;
        i_target_id <= r.id;
        i_target_position <= r.pos;
        i_target_velocity <= r.vel;
        i_stiffness_gain <= r.kp;
        i_damping_gain <= r.kd;
        i_feedforward_torque <= r.trq;
        do @(posedge i_clk); while (busy);
        pending_frames.push_back(known ? kf : encode_frame(r));
    endtask

    task automatic idle_for(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic maybe_idle();
        if (idling_on && $urandom_range(0, 3) == 0) idle_for($urandom_range(1, 19));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [2:0] idx, logic [30:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx < REG_SPARE_LO) limits[idx] = val;
    endtask

    function automatic logic [30:0] pick_limit();
        case ($urandom_range(0, 5))
            0: return 31'd0;
            1: return 31'd1;
            2: return 31'h7FFF_FFFF;
            3: return 31'($urandom_range(1, 100)) << 16;
            4: return 31'($urandom_range(1, 2000));
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic logic signed [31:0] pick_value(logic [30:0] lim);
        logic signed [31:0] x;
        case ($urandom_range(0, 7))
            0: x = $urandom;
            1: x = SMAX;
            2: x = SMIN;
            3: x = 32'(lim);
            4: x = 32'(lim) + 32'sd1;
            5: x = 32'sh0;
            default: x = $urandom_range(0, lim);
        endcase
        if ($urandom_range(0, 1)) x = -x;
        return x;
    endfunction

    function automatic motor_req_t random_req();
        motor_req_t r;
        int pick;
        pick = $urandom_range(0, 19);
        r.kind = (pick < 15) ? REQ_MOTION : (pick < 17) ? REQ_ENABLE :
                 (pick < 19) ? REQ_DISABLE : REQ_SPARE;
        r.bus = 8'($urandom);
        r.id = ($urandom_range(0, 24) == 0) ? 11'd0 : 11'($urandom_range(1, 2047));
        r.pos = pick_value(limits[REG_POSITION]);
        r.vel = pick_value(limits[REG_VELOCITY]);
        r.kp = pick_value(limits[REG_STIFFNESS]);
        r.kd = pick_value(limits[REG_DAMPING]);
        r.trq = pick_value(limits[REG_TORQUE]);
        return r;
    endfunction

    initial begin
        bit cfg_done;
        logic [30:0] lim;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        i_req_type <= REQ_MOTION;
        i_bus_index <= '0;
        i_target_id <= '0;
        i_target_position <= '0;
        i_target_velocity <= '0;
        i_stiffness_gain <= '0;
        i_damping_gain <= '0;
        i_feedforward_torque <= '0;
        foreach (limits[k]) limits[k] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cfg_done = 0;
        foreach (dir_rows[k]) begin
            if (dir_rows[k].after_cfg && !cfg_done) begin
                wait_drained();
                write_limit(REG_POSITION, 31'h0001_0000);
                write_limit(REG_VELOCITY, 31'h7FFF_FFFF);
                write_limit(REG_STIFFNESS, 31'd1);
                write_limit(REG_DAMPING, 31'h0032_0000);
                write_limit(REG_TORQUE, 31'd0);
                write_limit(REG_SPARE_LO, 31'h7FFF_FFFF);
                write_limit(REG_SPARE_HI, 31'h7FFF_FFFF);
                i_cfg_we <= 1'b0;
                cfg_done = 1;
            end
            send_req(dir_rows[k].req, dir_rows[k].known, dir_rows[k].frame);
            maybe_idle();
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            for (int r = 0; r < 5; r++) begin
                lim = (ph == 0) ? 31'h7FFF_FFFF : (ph == 1) ? 31'd1 : pick_limit();
                write_limit(3'(r), lim);
            end
            if ($urandom_range(0, 2) == 0)
                write_limit(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 31'($urandom));
            i_cfg_we <= 1'b0;
            idling_on = (ph < PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_req(random_req(), 1'b0, '0);
                if (n == PHASE_ITEMS / 2 && ph == 3) wait_drained();
                else maybe_idle();
            end
        end

        wait_drained();
        repeat (300) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
